### rtl/lks_pkg.sv
`default_nettype none

package lks_pkg;

  // Width of the millisecond time base; all differences wrap at this width.
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  // Most results one input item can cause.
  localparam int unsigned MaxRes = 4;
  localparam int unsigned ResIdxW = $clog2(MaxRes);
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);

  localparam logic [CfgW-1:0] PingIntervalRst   = CfgW'(500);
  localparam logic [CfgW-1:0] LinkTimeoutRst    = CfgW'(3000);
  localparam logic [CfgW-1:0] HsTimeoutRst      = CfgW'(1000);
  localparam logic [CfgW-1:0] ReconnBackoffRst  = CfgW'(1500);

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_ACK  = 2'd1,
    MODE_PONG = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ACT_NONE       = 4'd0,
    ACT_PING       = 4'd1,
    ACT_HANDSHAKE  = 4'd2,
    ACT_LOST       = 4'd3,
    ACT_HS_TIMEOUT = 4'd4,
    ACT_SWEEP      = 4'd5,
    ACT_ANIM       = 4'd6,
    ACT_KEYS       = 4'd7,
    ACT_READY      = 4'd8
  } action_e;

  typedef enum logic [1:0] {
    REG_PING_INTERVAL  = 2'd0,
    REG_LINK_TIMEOUT   = 2'd1,
    REG_HS_TIMEOUT     = 2'd2,
    REG_RECONN_BACKOFF = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] ping_interval;
    logic [CfgW-1:0] link_timeout;
    logic [CfgW-1:0] hs_timeout;
    logic [CfgW-1:0] reconn_backoff;
  } cfg_t;

  typedef struct packed {
    logic             connected;
    logic             hs_pending;
    logic [TimeW-1:0] ping_sent_time;
    logic [TimeW-1:0] pong_time;
    logic [TimeW-1:0] reconn_time;
    logic [TimeW-1:0] request_time;
    logic [7:0]       attempt_count;
  } state_t;

  typedef struct packed {
    action_e action;
    logic    link_up;
  } res_t;

  // All results of one input item, delivered one per transfer.
  typedef struct packed {
    res_t [MaxRes-1:0]  ents;
    logic [ResCntW-1:0] cnt;
  } bundle_t;

endpackage

`default_nettype wire

### rtl/lks_if.sv
`default_nettype none

interface lks_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] now_ms;

  modport source (output valid, output mode, output now_ms, input ready);
  modport sink   (input valid, input mode, input now_ms, output ready);
endinterface

interface lks_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic       link_up;
  logic       last;

  modport source (output valid, output action, output link_up, output last, input ready);
  modport sink   (input valid, input action, input link_up, input last, output ready);
endinterface

`default_nettype wire

### rtl/link_handshake_keepalive_core.sv
// Link keepalive and handshake supervisor.
// Events come in on evt_i: a tick, a handshake acknowledge or a pong, each
// stamped with the free-running millisecond time. Actions go out on res_o,
// one per transfer, with the link state after that action and a last flag
// on the final action caused by an event. Ticks with nothing due, pongs and
// the unused mode cause no action at all.
// An event is evaluated in the cycle it is accepted: the supervisor state
// updates at that edge and its actions are held in a result register, so
// the first action is offered in the next cycle. A tick yields at most two
// actions, an acknowledge three or four. A new event is accepted whenever
// the result register is empty or its last action transfers in the same
// cycle, so with res_o.ready high actions stream one per cycle and
// one-action events run at one per cycle; an event's accept waits for the
// previous event's remaining actions, which bounds the rate at one event
// per action delivered. When the receiver stalls, the current action holds
// and evt_i.ready drops once pending actions cannot drain. Reset clears
// the link state and timestamps and loads default intervals. The user must
// write registers via cfg_we_i only while the block is idle; not enforced.
`default_nettype none

module link_handshake_keepalive_core (
  input  var logic                      clk_i,
  input  var logic                      rst_ni,
  lks_evt_if.sink                       evt_i,
  lks_res_if.source                     res_o,
  input  var logic                      cfg_we_i,
  input  var logic [1:0]                cfg_idx_i,
  input  var logic [lks_pkg::CfgW-1:0]  cfg_wdata_i
);

  lks_pkg::cfg_t    cfg_q;
  lks_pkg::state_t  st_q;
  lks_pkg::state_t  st_d;
  lks_pkg::bundle_t bun_q;
  lks_pkg::bundle_t bun_d;
  logic [lks_pkg::ResIdxW-1:0] idx_q;

  logic res_last;
  logic res_fire;
  logic drain_done;
  logic evt_fire;

  // Configuration registers. Every 2-bit index names a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ping_interval  <= lks_pkg::PingIntervalRst;
      cfg_q.link_timeout   <= lks_pkg::LinkTimeoutRst;
      cfg_q.hs_timeout     <= lks_pkg::HsTimeoutRst;
      cfg_q.reconn_backoff <= lks_pkg::ReconnBackoffRst;
    end else if (cfg_we_i) begin
      unique case (lks_pkg::reg_idx_e'(cfg_idx_i))
        lks_pkg::REG_PING_INTERVAL:  cfg_q.ping_interval  <= cfg_wdata_i;
        lks_pkg::REG_LINK_TIMEOUT:   cfg_q.link_timeout   <= cfg_wdata_i;
        lks_pkg::REG_HS_TIMEOUT:     cfg_q.hs_timeout     <= cfg_wdata_i;
        lks_pkg::REG_RECONN_BACKOFF: cfg_q.reconn_backoff <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // The whole decision for one event happens in this combinational step.
  lks_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .mode_i (evt_i.mode),
    .now_i  (evt_i.now_ms[lks_pkg::TimeW-1:0]),
    .st_o   (st_d),
    .bun_o  (bun_d)
  );

  // The output side walks the stored action list; the last flag marks the
  // final entry so the input side knows when the register frees up.
  assign res_o.valid   = (bun_q.cnt != '0);
  assign res_o.action  = bun_q.ents[idx_q].action;
  assign res_o.link_up = bun_q.ents[idx_q].link_up;
  assign res_last      = ({1'b0, idx_q} == (bun_q.cnt - 1'b1));
  assign res_o.last    = res_last;

  assign res_fire   = res_o.valid && res_o.ready;
  assign drain_done = res_fire && res_last;
  assign evt_i.ready = !res_o.valid || drain_done;
  assign evt_fire   = evt_i.valid && evt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      bun_q <= '0;
      idx_q <= '0;
    end else begin
      if (evt_fire) begin
        // A new event replaces a fully delivered list; a quiet event leaves
        // the list empty.
        st_q  <= st_d;
        bun_q <= bun_d;
        idx_q <= '0;
      end else if (drain_done) begin
        bun_q.cnt <= '0;
        idx_q     <= '0;
      end else if (res_fire) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/lks_step.sv
`default_nettype none

// Next state and the full result list for one event, in one pass.
module lks_step (
  input  var lks_pkg::state_t             st_i,
  input  var lks_pkg::cfg_t               cfg_i,
  input  var logic [1:0]                  mode_i,
  input  var logic [lks_pkg::TimeW-1:0]   now_i,
  output lks_pkg::state_t                 st_o,
  output lks_pkg::bundle_t                bun_o
);

  logic [lks_pkg::TimeW-1:0]   el_ping;
  logic [lks_pkg::TimeW-1:0]   el_pong;
  logic [lks_pkg::TimeW-1:0]   el_reconn;
  logic [lks_pkg::TimeW-1:0]   el_req;
  logic [lks_pkg::ResCntW-1:0] n;

  // Elapsed times wrap naturally at the time width.
  assign el_ping   = now_i - st_i.ping_sent_time;
  assign el_pong   = now_i - st_i.pong_time;
  assign el_reconn = now_i - st_i.reconn_time;
  assign el_req    = now_i - st_i.request_time;

  always_comb begin
    st_o  = st_i;
    bun_o = '0;
    n     = '0;
    unique case (lks_pkg::mode_e'(mode_i))
      lks_pkg::MODE_TICK: begin
        if (st_i.connected) begin
          if (el_ping >= lks_pkg::TimeW'(cfg_i.ping_interval)) begin
            st_o.ping_sent_time = now_i;
            bun_o.ents[n[lks_pkg::ResIdxW-1:0]] = '{action: lks_pkg::ACT_PING, link_up: 1'b1};
            n = n + 1'b1;
          end
          if ((st_i.pong_time != '0) &&
              (el_pong > lks_pkg::TimeW'(cfg_i.link_timeout))) begin
            st_o.connected      = 1'b0;
            st_o.hs_pending     = 1'b0;
            st_o.pong_time      = '0;
            st_o.ping_sent_time = '0;
            bun_o.ents[n[lks_pkg::ResIdxW-1:0]] = '{action: lks_pkg::ACT_LOST, link_up: 1'b0};
            n = n + 1'b1;
          end
        end else if (!st_i.hs_pending &&
                     (el_reconn >= lks_pkg::TimeW'(cfg_i.reconn_backoff))) begin
          st_o.hs_pending    = 1'b1;
          st_o.request_time  = now_i;
          st_o.reconn_time   = now_i;
          st_o.attempt_count = st_i.attempt_count + 8'd1;
          bun_o.ents[0] = '{action: lks_pkg::ACT_HANDSHAKE, link_up: 1'b0};
          n = n + 1'b1;
        end else if (st_i.hs_pending &&
                     (el_req > lks_pkg::TimeW'(cfg_i.hs_timeout))) begin
          st_o.hs_pending = 1'b0;
          bun_o.ents[0] = '{action: lks_pkg::ACT_HS_TIMEOUT, link_up: 1'b0};
          n = n + 1'b1;
        end
      end
      lks_pkg::MODE_ACK: begin
        if (!st_i.connected) begin
          st_o.connected      = 1'b1;
          st_o.hs_pending     = 1'b0;
          st_o.attempt_count  = '0;
          st_o.pong_time      = now_i;
          st_o.ping_sent_time = now_i;
          bun_o.ents[0] = '{action: lks_pkg::ACT_SWEEP, link_up: 1'b1};
          n = n + 1'b1;
        end
        bun_o.ents[n[lks_pkg::ResIdxW-1:0]] = '{action: lks_pkg::ACT_ANIM, link_up: 1'b1};
        n = n + 1'b1;
        bun_o.ents[n[lks_pkg::ResIdxW-1:0]] = '{action: lks_pkg::ACT_KEYS, link_up: 1'b1};
        n = n + 1'b1;
        bun_o.ents[n[lks_pkg::ResIdxW-1:0]] = '{action: lks_pkg::ACT_READY, link_up: 1'b1};
        n = n + 1'b1;
      end
      lks_pkg::MODE_PONG: begin
        st_o.pong_time = now_i;
      end
      default: begin
      end
    endcase
    bun_o.cnt = n;
  end

endmodule

`default_nettype wire
